// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL. Each macro samples on clk and is
// disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/vad_pkg.sv =====
`default_nettype none

package vad_pkg;

  // Angle accumulator: degrees with 24 fraction bits, signed, 33 bits wide.
  localparam int ACC_FRAC = 24;
  localparam int ZW       = 33;
  localparam int OUT_W    = 16;

  localparam logic signed [ZW-1:0] Z_90  = ZW'(90) << ACC_FRAC;
  localparam logic signed [ZW-1:0] Z_180 = ZW'(180) << ACC_FRAC;

  // atan(2^-i) in degrees with 24 fraction bits, rounded to nearest.
  function automatic logic signed [ZW-1:0] atan_deg(input logic [4:0] idx);
    logic signed [ZW-1:0] a;
    unique case (idx)
      5'd0:  a = ZW'(754974720);
      5'd1:  a = ZW'(445687602);
      5'd2:  a = ZW'(235489088);
      5'd3:  a = ZW'(119537938);
      5'd4:  a = ZW'(60000934);
      5'd5:  a = ZW'(30029717);
      5'd6:  a = ZW'(15018523);
      5'd7:  a = ZW'(7509720);
      5'd8:  a = ZW'(3754917);
      5'd9:  a = ZW'(1877466);
      5'd10: a = ZW'(938734);
      5'd11: a = ZW'(469367);
      5'd12: a = ZW'(234684);
      5'd13: a = ZW'(117342);
      5'd14: a = ZW'(58671);
      5'd15: a = ZW'(29335);
      5'd16: a = ZW'(14668);
      5'd17: a = ZW'(7334);
      5'd18: a = ZW'(3667);
      5'd19: a = ZW'(1833);
      5'd20: a = ZW'(917);
      5'd21: a = ZW'(458);
      5'd22: a = ZW'(229);
      5'd23: a = ZW'(115);
      5'd24: a = ZW'(57);
      5'd25: a = ZW'(29);
      5'd26: a = ZW'(14);
      5'd27: a = ZW'(7);
      5'd28: a = ZW'(4);
      5'd29: a = ZW'(2);
      5'd30: a = ZW'(1);
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/vad_front.sv =====
`default_nettype none

// Four stages: differences, products, dot/cross sums, CORDIC start vector.
module vad_front import vad_pkg::*; #(
  parameter int COORD_WIDTH = 16
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                up_valid,
  output logic                               up_ready,
  input  wire  signed [COORD_WIDTH-1:0]      end_a_x,
  input  wire  signed [COORD_WIDTH-1:0]      end_a_y,
  input  wire  signed [COORD_WIDTH-1:0]      vertex_x,
  input  wire  signed [COORD_WIDTH-1:0]      vertex_y,
  input  wire  signed [COORD_WIDTH-1:0]      end_b_x,
  input  wire  signed [COORD_WIDTH-1:0]      end_b_y,
  output logic                               dn_valid,
  input  wire                                dn_ready,
  output logic signed [2*COORD_WIDTH+3:0]    x,
  output logic signed [2*COORD_WIDTH+3:0]    y,
  output logic signed [ZW-1:0]               z,
  output logic                               nz
);

  localparam int DW = COORD_WIDTH + 1;
  localparam int PW = 2 * DW;
  localparam int SW = PW + 1;
  localparam int XW = SW + 1;

  logic v1, v2, v3;
  logic adv1, adv2, adv3, adv4;

  logic signed [DW-1:0] ux, uy, wx, wy;
  logic                 nz1, nz2, nz3;
  logic signed [PW-1:0] p_xx, p_yy, p_xy, p_yx;
  logic signed [SW-1:0] d, c;

  logic signed [XW-1:0] dx, cx, cabs;
  logic signed [XW-1:0] x_next, y_next;
  logic signed [ZW-1:0] z_next;

  assign adv4     = !dn_valid || dn_ready;
  assign adv3     = !v3 || adv4;
  assign adv2     = !v2 || adv3;
  assign adv1     = !v1 || adv2;
  assign up_ready = adv1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      v2       <= 1'b0;
      v3       <= 1'b0;
      dn_valid <= 1'b0;
    end else begin
      if (adv1) v1 <= up_valid;
      if (adv2) v2 <= v1;
      if (adv3) v3 <= v2;
      if (adv4) dn_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      ux  <= DW'(end_a_x) - DW'(vertex_x);
      uy  <= DW'(end_a_y) - DW'(vertex_y);
      wx  <= DW'(end_b_x) - DW'(vertex_x);
      wy  <= DW'(end_b_y) - DW'(vertex_y);
      nz1 <= ((end_a_x != vertex_x) || (end_a_y != vertex_y)) &&
             ((end_b_x != vertex_x) || (end_b_y != vertex_y));
    end
    if (adv2) begin
      p_xx <= ux * wx;
      p_yy <= uy * wy;
      p_xy <= ux * wy;
      p_yx <= uy * wx;
      nz2  <= nz1;
    end
    if (adv3) begin
      d   <= SW'(p_xx) + SW'(p_yy);
      c   <= SW'(p_xy) - SW'(p_yx);
      nz3 <= nz2;
    end
    if (adv4) begin
      x  <= x_next;
      y  <= y_next;
      z  <= z_next;
      nz <= nz3;
    end
  end

  // An obtuse angle starts from the vector turned by -90 degrees.
  always_comb begin
    dx   = XW'(d);
    cx   = XW'(c);
    cabs = cx[XW-1] ? -cx : cx;
    if (d[SW-1]) begin
      x_next = cabs;
      y_next = -dx;
      z_next = Z_90;
    end else begin
      x_next = dx;
      y_next = cabs;
      z_next = '0;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/vad_cordic_step.sv =====
`default_nettype none

// One registered CORDIC vectoring iteration.
module vad_cordic_step import vad_pkg::*; #(
  parameter int XW   = 36,
  parameter int STEP = 0
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  up_valid,
  output logic                 up_ready,
  input  wire  signed [XW-1:0] x_in,
  input  wire  signed [XW-1:0] y_in,
  input  wire  signed [ZW-1:0] z_in,
  input  wire                  nz_in,
  output logic                 dn_valid,
  input  wire                  dn_ready,
  output logic signed [XW-1:0] x,
  output logic signed [XW-1:0] y,
  output logic signed [ZW-1:0] z,
  output logic                 nz
);

  // Steps past the end of the arctangent table add nothing to the angle.
  localparam logic signed [ZW-1:0] ANGLE = (STEP < 32) ? atan_deg(5'(STEP)) : '0;

  logic                 adv;
  logic signed [XW-1:0] xs, ys, x_next, y_next;
  logic signed [ZW-1:0] z_next;

  assign adv      = !dn_valid || dn_ready;
  assign up_ready = adv;

  // Arithmetic shifts round toward minus infinity.
  always_comb begin
    xs = x_in >>> STEP;
    ys = y_in >>> STEP;
    if (!y_in[XW-1]) begin
      x_next = x_in + ys;
      y_next = y_in - xs;
      z_next = z_in + ANGLE;
    end else begin
      x_next = x_in - ys;
      y_next = y_in + xs;
      z_next = z_in - ANGLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (adv) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x  <= x_next;
      y  <= y_next;
      z  <= z_next;
      nz <= nz_in;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/vad_finish.sv =====
`default_nettype none

// Saturates the accumulator to 0..180 degrees and rounds to the output format, or gives 0 for a zero-length vector.
module vad_finish import vad_pkg::*; #(
  parameter int ANGLE_FRAC_BITS = 8
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  up_valid,
  output logic                 up_ready,
  input  wire  signed [ZW-1:0] z_in,
  input  wire                  nz_in,
  output logic                 dn_valid,
  input  wire                  dn_ready,
  output logic [OUT_W-1:0]     angle,
  output logic                 angle_valid
);

  localparam int          RSH = ACC_FRAC - ANGLE_FRAC_BITS;
  localparam logic [31:0] RND = 32'(1) << (RSH - 1);

  logic              adv;
  logic [31:0]       zc, zr, qs;
  logic [OUT_W-1:0]  angle_next;

  assign adv      = !dn_valid || dn_ready;
  assign up_ready = adv;

  always_comb begin
    if (z_in[ZW-1]) begin
      zc = '0;
    end else if (z_in > Z_180) begin
      zc = Z_180[31:0];
    end else begin
      zc = z_in[31:0];
    end
    zr         = zc + RND;
    qs         = zr >> RSH;
    angle_next = nz_in ? qs[OUT_W-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (adv) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      angle       <= angle_next;
      angle_valid <= nz_in;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/vector_angle_degrees.sv =====
// Unsigned angle at a vertex between two endpoints, in degrees.
// Input channel: in_valid / in_stall carry one transaction of three points
// (end_a, vertex, end_b), each coordinate COORD_WIDTH bits two's complement.
// Output channel: out_valid / out_stall carry one transaction per input:
// angle_deg_q8 holds 0..180 degrees with ANGLE_FRAC_BITS fraction bits, and
// angle_valid is 0 (with a zero angle) when either vector has zero length.
// The datapath is a pipeline of 5 + CORDIC_STEPS register stages: four for
// differences, products, dot/cross sums and the start vector, one per CORDIC
// iteration, and one for saturation and rounding. A new transaction can be
// accepted every cycle while out_stall is low.
// Each stage holds its own valid bit and moves forward when the next stage is
// empty or moving, so bubbles are squeezed out while out_stall is high and
// in_stall rises only once every stage holds a transaction.
// A synchronous reset empties the pipeline; no result is pending afterward.
`default_nettype none

`include "assert_macros.svh"

module vector_angle_degrees import vad_pkg::*; #(
  parameter int COORD_WIDTH     = 16,
  parameter int ANGLE_FRAC_BITS = 8,
  parameter int CORDIC_STEPS    = 16
) (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           in_valid,
  output logic                          in_stall,
  input  wire  signed [COORD_WIDTH-1:0] end_a_x,
  input  wire  signed [COORD_WIDTH-1:0] end_a_y,
  input  wire  signed [COORD_WIDTH-1:0] vertex_x,
  input  wire  signed [COORD_WIDTH-1:0] vertex_y,
  input  wire  signed [COORD_WIDTH-1:0] end_b_x,
  input  wire  signed [COORD_WIDTH-1:0] end_b_y,
  output logic                          out_valid,
  input  wire                           out_stall,
  output logic [OUT_W-1:0]              angle_deg_q8,
  output logic                          angle_valid
);

  // CORDIC x/y width: the dot and cross sums plus room for the CORDIC gain.
  localparam int XW = 2 * COORD_WIDTH + 4;
  localparam logic [OUT_W-1:0] ANGLE_MAX = OUT_W'(180 << ANGLE_FRAC_BITS);

  // Index k is the handoff into CORDIC step k; the last one feeds the finish.
  logic                 sv   [CORDIC_STEPS+1];
  logic                 srdy [CORDIC_STEPS+1];
  logic signed [XW-1:0] sx   [CORDIC_STEPS+1];
  logic signed [XW-1:0] sy   [CORDIC_STEPS+1];
  logic signed [ZW-1:0] sz   [CORDIC_STEPS+1];
  logic                 snz  [CORDIC_STEPS+1];

  logic front_ready;

  assign in_stall = !front_ready;

  vad_front #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .up_valid (in_valid),
    .up_ready (front_ready),
    .end_a_x  (end_a_x),
    .end_a_y  (end_a_y),
    .vertex_x (vertex_x),
    .vertex_y (vertex_y),
    .end_b_x  (end_b_x),
    .end_b_y  (end_b_y),
    .dn_valid (sv[0]),
    .dn_ready (srdy[0]),
    .x        (sx[0]),
    .y        (sy[0]),
    .z        (sz[0]),
    .nz       (snz[0])
  );

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    vad_cordic_step #(
      .XW   (XW),
      .STEP (i)
    ) u_step (
      .clk      (clk),
      .rst      (rst),
      .up_valid (sv[i]),
      .up_ready (srdy[i]),
      .x_in     (sx[i]),
      .y_in     (sy[i]),
      .z_in     (sz[i]),
      .nz_in    (snz[i]),
      .dn_valid (sv[i+1]),
      .dn_ready (srdy[i+1]),
      .x        (sx[i+1]),
      .y        (sy[i+1]),
      .z        (sz[i+1]),
      .nz       (snz[i+1])
    );
  end

  vad_finish #(
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
  ) u_finish (
    .clk         (clk),
    .rst         (rst),
    .up_valid    (sv[CORDIC_STEPS]),
    .up_ready    (srdy[CORDIC_STEPS]),
    .z_in        (sz[CORDIC_STEPS]),
    .nz_in       (snz[CORDIC_STEPS]),
    .dn_valid    (out_valid),
    .dn_ready    (!out_stall),
    .angle       (angle_deg_q8),
    .angle_valid (angle_valid)
  );

  // A degenerate input must come out with a zero angle.
  `ASSERT_IMPLIES(a_zero_len_angle, out_valid && !angle_valid, angle_deg_q8 == '0, "nonzero angle for zero-length vector")

  // The saturated result never exceeds 180 degrees when it fits the port.
  `ASSERT_IMPLIES(a_angle_range, out_valid, (ANGLE_FRAC_BITS > 8) || (angle_deg_q8 <= ANGLE_MAX), "angle above 180 degrees")

  // With the output draining, every stage can advance, so input never stalls.
  `ASSERT_IMPLIES(a_no_stall_when_draining, !out_stall, !in_stall, "input stalled while output drains")

  // An empty finish stage with no input cannot show a result in the next cycle.
  `ASSERT_NEXT(a_empty_after_idle, !sv[CORDIC_STEPS] && !out_valid, !out_valid, "result appeared from an empty stage")

endmodule

`default_nettype wire

// ===== tb/vector_angle_degrees_checker.sv =====
// Watches both channels of vector_angle_degrees. Every accepted point triple is
// run through a bit-exact CORDIC model, and the expected angle is queued. Each
// accepted result is compared with the oldest queued angle.
module vector_angle_degrees_checker import vad_pkg::*; (
  input  wire                clk,
  input  wire                rst,
  input  wire                in_valid,
  input  wire                in_stall,
  input  wire signed [15:0]  end_a_x,
  input  wire signed [15:0]  end_a_y,
  input  wire signed [15:0]  vertex_x,
  input  wire signed [15:0]  vertex_y,
  input  wire signed [15:0]  end_b_x,
  input  wire signed [15:0]  end_b_y,
  input  wire                out_valid,
  input  wire                out_stall,
  input  wire [OUT_W-1:0]    angle_deg_q8,
  input  wire                angle_valid,
  output int                 mismatch_count,
  output int                 pending_count,
  output int                 result_count,
  output int                 zero_length_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int    STEPS      = 16;
  localparam int    FRAC_OUT   = 8;
  localparam int    FRAC_ACC   = 24;
  localparam longint DEG_90    = longint'(90) << FRAC_ACC;
  localparam longint DEG_180   = longint'(180) << FRAC_ACC;

  // Arctangent of 2^-i in degrees, 24 fraction bits.
  localparam longint ATAN_Q24 [0:31] = '{
    754974720, 445687602, 235489088, 119537938,
    60000934, 30029717, 15018523, 7509720,
    3754917, 1877466, 938734, 469367,
    234684, 117342, 58671, 29335,
    14668, 7334, 3667, 1833,
    917, 458, 229, 115,
    57, 29, 14, 7,
    4, 2, 1, 0
  };

  typedef struct packed {
    logic [OUT_W-1:0] angle;
    logic             nonzero;
  } angle_t;

  angle_t expected_angles[$];

  function automatic angle_t predict_angle(input logic signed [15:0] ax, ay, vx, vy, bx, by);
    longint ux, uy, wx, wy;
    longint dot_p, cross_p;
    longint cx, cy, acc, cx_next, sx, sy;
    angle_t r;
    ux = longint'(ax) - longint'(vx);
    uy = longint'(ay) - longint'(vy);
    wx = longint'(bx) - longint'(vx);
    wy = longint'(by) - longint'(vy);
    r = '0;
    if ((ux == 0 && uy == 0) || (wx == 0 && wy == 0))
      return r;
    dot_p   = ux * wx + uy * wy;
    cross_p = ux * wy - uy * wx;
    if (cross_p < 0)
      cross_p = -cross_p;
    // An obtuse pair is first turned by a right angle so that vectoring
    // always starts in the right half plane.
    if (dot_p < 0) begin
      cx  = cross_p;
      cy  = -dot_p;
      acc = DEG_90;
    end else begin
      cx  = dot_p;
      cy  = cross_p;
      acc = 0;
    end
    for (int i = 0; i < STEPS; i++) begin
      sx = cx >>> i;
      sy = cy >>> i;
      if (cy >= 0) begin
        cx_next = cx + sy;
        cy      = cy - sx;
        acc     = acc + ((i < 32) ? ATAN_Q24[i] : 0);
      end else begin
        cx_next = cx - sy;
        cy      = cy + sx;
        acc     = acc - ((i < 32) ? ATAN_Q24[i] : 0);
      end
      cx = cx_next;
    end
    if (acc < 0)
      acc = 0;
    if (acc > DEG_180)
      acc = DEG_180;
    acc = (acc + (longint'(1) << (FRAC_ACC - FRAC_OUT - 1))) >>> (FRAC_ACC - FRAC_OUT);
    r.angle   = OUT_W'(acc);
    r.nonzero = 1'b1;
    return r;
  endfunction

  task automatic note_mismatch(input string what, input angle_t want, input angle_t got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("[%0t] %s: expected angle %0d valid %0b, got angle %0d valid %0b",
               $realtime, what, want.angle, want.nonzero, got.angle, got.nonzero);
  endtask

  always @(posedge clk) begin : monitor
    angle_t want;
    angle_t got;
    if (rst) begin
      mismatch_count    = 0;
      pending_count     = 0;
      result_count      = 0;
      zero_length_count = 0;
      expected_angles.delete();
    end else begin
      // Results are retired before new inputs are queued so that a spurious
      // result can never pair with a triple that entered in the same cycle.
      if (out_valid && !out_stall) begin
        got.angle   = angle_deg_q8;
        got.nonzero = angle_valid;
        result_count++;
        if (expected_angles.size() == 0) begin
          note_mismatch("result with nothing outstanding", '0, got);
        end else begin
          want = expected_angles.pop_front();
          if (!want.nonzero)
            zero_length_count++;
          if (got.angle !== want.angle)
            note_mismatch("angle_deg_q8 differs", want, got);
          if (got.nonzero !== want.nonzero)
            note_mismatch("angle_valid differs", want, got);
        end
      end
      if (in_valid && !in_stall)
        expected_angles.insert(expected_angles.size(),
                               predict_angle(end_a_x, end_a_y, vertex_x, vertex_y,
                                             end_b_x, end_b_y));
      pending_count = expected_angles.size();
    end
  end

endmodule

// ===== tb/vector_angle_degrees_test.sv =====
// Stimulus and verdict for vector_angle_degrees. The checker instance beside
// the block does all prediction and comparison; this module only produces
// point triples, toggles back-pressure, and decides pass or fail at the end.
module vector_angle_degrees_test;
  import vad_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [15:0] coord_t;

  // Cycles with no transaction on either channel before the run is abandoned.
  // The slowest legal stretch is a full pipeline drain under heavy stalling.
  localparam int IDLE_LIMIT     = 4000;
  localparam int ITEMS_PER_PHASE = 435;
  // The tail wait covers the depth of the pipeline.
  localparam int TAIL_CYCLES    = 40;

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   in_valid = 1'b0;
  logic   in_stall;
  coord_t end_a_x = '0;
  coord_t end_a_y = '0;
  coord_t vertex_x = '0;
  coord_t vertex_y = '0;
  coord_t end_b_x = '0;
  coord_t end_b_y = '0;
  logic   out_valid;
  logic   out_stall = 1'b0;
  logic [OUT_W-1:0] angle_deg_q8;
  logic   angle_valid;

  int mismatch_count;
  int pending_count;
  int result_count;
  int zero_length_count;

  // Percentages for the current flow-control phase.
  int idle_pct  = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  vector_angle_degrees u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .end_a_x      (end_a_x),
    .end_a_y      (end_a_y),
    .vertex_x     (vertex_x),
    .vertex_y     (vertex_y),
    .end_b_x      (end_b_x),
    .end_b_y      (end_b_y),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .angle_deg_q8 (angle_deg_q8),
    .angle_valid  (angle_valid)
  );

  vector_angle_degrees_checker u_checker (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .end_a_x           (end_a_x),
    .end_a_y           (end_a_y),
    .vertex_x          (vertex_x),
    .vertex_y          (vertex_y),
    .end_b_x           (end_b_x),
    .end_b_y           (end_b_y),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .angle_deg_q8      (angle_deg_q8),
    .angle_valid       (angle_valid),
    .mismatch_count    (mismatch_count),
    .pending_count     (pending_count),
    .result_count      (result_count),
    .zero_length_count (zero_length_count)
  );

  // Back-pressure on the result channel is redrawn every cycle at the
  // falling edge, so the block sees it settled well before the next rising edge.
  always @(negedge clk)
    out_stall <= ($urandom_range(99) < stall_pct);

  // Count cycles in which neither channel completes a transaction. Any real
  // activity resets the count, so only a hung block trips the watchdog.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < IDLE_LIMIT)
      @(posedge clk);
    $display("Watchdog: no transaction for %0d cycles, %0d results still outstanding",
             IDLE_LIMIT, pending_count);
    $display("CHECK FAILED");
    $finish;
  end

  // Offer one point triple and hold it until the block takes it. Idle cycles
  // are inserted up front, so the valid line is only ever assigned once per
  // falling edge: low during a gap, then high with the new payload.
  task automatic send_points(input coord_t ax, ay, vx, vy, bx, by);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    end_a_x  <= ax;
    end_a_y  <= ay;
    vertex_x <= vx;
    vertex_y <= vy;
    end_b_x  <= bx;
    end_b_y  <= by;
    in_valid <= 1'b1;
    do
      @(posedge clk);
    while (in_stall);
  endtask

  // Hold off the sender until every result in flight has been returned.
  task automatic drain_pipeline();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_count != 0)
      @(negedge clk);
  endtask

  function automatic coord_t pick_extreme();
    case ($urandom_range(4))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2:       return -16'sd1;
      3:       return 16'sd1;
      default: return 16'sd0;
    endcase
  endfunction

  // Draw one random triple. Just under half are unconstrained; the rest are
  // steered toward the interesting geometry: short vectors, zero-length
  // vectors, collinear and perpendicular pairs, and the coordinate extremes.
  task automatic pick_points(output coord_t ax, ay, vx, vy, bx, by);
    int mode;
    int ox, oy, k;
    mode = $urandom_range(99);
    ax = coord_t'($urandom());
    ay = coord_t'($urandom());
    vx = coord_t'($urandom());
    vy = coord_t'($urandom());
    bx = coord_t'($urandom());
    by = coord_t'($urandom());
    if (mode < 45) begin
      // Fully random coordinates cover every input bit in both states.
    end else if (mode < 70) begin
      vx = coord_t'(int'($urandom_range(60000)) - 30000);
      vy = coord_t'(int'($urandom_range(60000)) - 30000);
      ax = coord_t'(int'(vx) + int'($urandom_range(200)) - 100);
      ay = coord_t'(int'(vy) + int'($urandom_range(200)) - 100);
      bx = coord_t'(int'(vx) + int'($urandom_range(200)) - 100);
      by = coord_t'(int'(vy) + int'($urandom_range(200)) - 100);
    end else if (mode < 80) begin
      case ($urandom_range(2))
        0: begin ax = vx; ay = vy; end
        1: begin bx = vx; by = vy; end
        default: begin ax = vx; ay = vy; bx = vx; by = vy; end
      endcase
    end else if (mode < 92) begin
      // The second vector is an integer multiple of the first, or of the
      // first turned by a right angle: exact 0, 90 and 180 degree cases.
      vx = coord_t'(int'($urandom_range(40000)) - 20000);
      vy = coord_t'(int'($urandom_range(40000)) - 20000);
      ox = int'($urandom_range(2000)) - 1000;
      oy = int'($urandom_range(2000)) - 1000;
      k  = int'($urandom_range(5)) - 2;
      if (k >= 0)
        k = k + 1;
      ax = coord_t'(int'(vx) + ox);
      ay = coord_t'(int'(vy) + oy);
      if ($urandom_range(1)) begin
        bx = coord_t'(int'(vx) + k * ox);
        by = coord_t'(int'(vy) + k * oy);
      end else begin
        bx = coord_t'(int'(vx) - k * oy);
        by = coord_t'(int'(vy) + k * ox);
      end
    end else begin
      ax = pick_extreme();
      ay = pick_extreme();
      vx = pick_extreme();
      vy = pick_extreme();
      bx = pick_extreme();
      by = pick_extreme();
    end
  endtask

  initial begin : stimulus
    coord_t ax, ay, vx, vy, bx, by;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int phase = 0; phase < 4; phase++) begin
      // Phase 0 runs at full rate, phase 1 starves the input, phase 2 stalls
      // the output, and phase 3 mixes light idling on both sides.
      case (phase)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 54; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 54; end
        default: begin idle_pct = 17; stall_pct = 17; end
      endcase

      if (phase == 0) begin
        // Zero-length vectors: first, second, both, and everything at origin.
        send_points(16'sd100, -16'sd50, 16'sd100, -16'sd50, 16'sd7, 16'sd9);
        send_points(16'sd3, 16'sd4, -16'sd20, 16'sd11, -16'sd20, 16'sd11);
        send_points(16'sd5, 16'sd5, 16'sd5, 16'sd5, 16'sd5, 16'sd5);
        send_points(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
        // Same direction, where the residual starts at exactly zero.
        send_points(16'sd10, 16'sd0, 16'sd0, 16'sd0, 16'sd20, 16'sd0);
        // Opposite directions give a straight angle.
        send_points(16'sd10, 16'sd0, 16'sd0, 16'sd0, -16'sd20, 16'sd0);
        // Right angles with a zero dot product, cross product of either sign.
        send_points(16'sd5, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd7);
        send_points(16'sd5, 16'sd0, 16'sd0, 16'sd0, 16'sd0, -16'sd7);
        // Plain acute and obtuse angles.
        send_points(16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd1, 16'sd1);
        send_points(16'sd1, 16'sd0, 16'sd0, 16'sd0, -16'sd1, 16'sd1);
        // Coordinate extremes produce the widest differences and products.
        send_points(16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh8000);
        send_points(16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh7fff);
        send_points(16'sh7fff, 16'sd0, 16'sd0, 16'sd0, 16'sh8000, 16'sd0);
        send_points(16'sh8000, 16'sh8000, 16'sd0, 16'sd0, 16'sh8000, 16'sh8000);
        // Slivers close to zero and to a straight angle.
        send_points(16'sh7fff, 16'sd0, 16'sd0, 16'sd0, 16'sh7fff, 16'sd1);
        send_points(16'sh7fff, 16'sd0, 16'sd0, 16'sd0, 16'sh8000, 16'sd1);
        // Obtuse rotation taken: just past a right angle, and nearly straight.
        send_points(16'sd1000, 16'sd0, 16'sd0, 16'sd0, -16'sd1, 16'sd1000);
        send_points(16'sh7fff, 16'sh8000, -16'sd1, -16'sd1, 16'sh8000, 16'sh7fff);
      end

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if ((phase == 1 || phase == 3) && n == ITEMS_PER_PHASE / 2)
          drain_pipeline();
        pick_points(ax, ay, vx, vy, bx, by);
        send_points(ax, ay, vx, vy, bx, by);
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_count != 0)
      @(negedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d angle results (%0d with a zero-length vector) over four",
             result_count, zero_length_count);
    $display("flow-control phases, including full-rate, starved, stalled and drained runs.");
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches, %0d results never returned", mismatch_count, pending_count);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== vector_angle_degrees.f =====
+incdir+rtl
rtl/vad_pkg.sv
rtl/vad_front.sv
rtl/vad_cordic_step.sv
rtl/vad_finish.sv
rtl/vector_angle_degrees.sv
tb/vector_angle_degrees_checker.sv
tb/vector_angle_degrees_test.sv
